### hw/rtl/htfs_pkg.sv
// Shared constants, types and helpers for the header/tail frame synchronizer.
`timescale 1ns / 1ps
`default_nettype none
package htfs_pkg;

  localparam int FRAME_LENGTH = 24;
  localparam int CNT_W        = $clog2(FRAME_LENGTH);
  localparam int BYTE_W       = 8;
  localparam int POS_W        = 5;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(FRAME_LENGTH - 1);
  localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(2);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FIRST_HDR  = 2'd0;
  localparam logic [1:0] REG_SECOND_HDR = 2'd1;
  localparam logic [1:0] REG_TAIL       = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_WAIT2   = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  // Per-cycle commands from the controller to the two cell chains.
  typedef struct packed {
    logic hdr_load;
    logic coll_shift;
    logic out_load;
    logic out_shift;
  } ctl_t;

  // Frame position as reported on the result channel, wrapping at 32.
  function automatic logic [POS_W-1:0] to_position(input logic [CNT_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/htfs_cell.sv
// One byte cell of a chain: loads a value, takes its neighbor's byte, or holds.
`timescale 1ns / 1ps
`default_nettype none
module htfs_cell
  import htfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              shift_en,
  input  wire logic [BYTE_W-1:0] shift_in,
  input  wire logic              load_en,
  input  wire logic [BYTE_W-1:0] load_in,
  output logic      [BYTE_W-1:0] q
);

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load_en) begin
      data_nxt = load_in;
    end else if (shift_en) begin
      data_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule
`default_nettype wire

### hw/rtl/htfs_ctrl.sv
// Sync state machine, fill counter and result sequencing for the cell chains.
`timescale 1ns / 1ps
`default_nettype none
module htfs_ctrl
  import htfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [BYTE_W-1:0] first_hdr,
  input  wire logic [BYTE_W-1:0] second_hdr,
  input  wire logic [BYTE_W-1:0] tail,
  input  wire logic              out_stall,
  output logic                   in_stall,
  output logic                   out_valid,
  output logic      [POS_W-1:0]  out_position,
  output logic                   out_last,
  output ctl_t                   ctl
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             busy_r, busy_nxt;
  logic             accept;
  logic             out_free;

  // The result chain can take a new frame once its last word leaves.
  assign out_free = !busy_r || (pos_r == LAST_IDX && !out_stall);
  assign in_stall = (phase_r == PH_COLLECT) && (fill_r == LAST_IDX) && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      fill_r  <= '0;
      pos_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    fill_nxt       = fill_r;
    ctl.hdr_load   = 1'b0;
    ctl.coll_shift = 1'b0;
    ctl.out_load   = 1'b0;
    ctl.out_shift  = busy_r && !out_stall;
    case (phase_r)
      PH_WAIT2: begin
        if (accept) begin
          if (rx_byte == second_hdr) begin
            ctl.hdr_load = 1'b1;
            fill_nxt     = HDR_BYTES;
            phase_nxt    = PH_COLLECT;
          end else if (rx_byte != first_hdr) begin
            phase_nxt = PH_HUNT;
          end
        end
      end
      PH_COLLECT: begin
        if (accept) begin
          ctl.coll_shift = 1'b1;
          if (fill_r == LAST_IDX) begin
            fill_nxt     = '0;
            phase_nxt    = PH_HUNT;
            ctl.out_load = (rx_byte == tail);
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
      end
      default: begin
        if (accept) begin
          phase_nxt = (rx_byte == first_hdr) ? PH_WAIT2 : PH_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    if (ctl.out_load) begin
      pos_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (ctl.out_shift) begin
      if (pos_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + CNT_W'(1);
      end
    end
  end

  assign out_valid    = busy_r;
  assign out_position = to_position(pos_r);
  assign out_last     = (pos_r == LAST_IDX);

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!busy_r || (pos_r == LAST_IDX && !out_stall)))
    else $error("new frame loaded over one still being delivered");

  a_hdr_starts_collect: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.hdr_load |=> (phase_r == PH_COLLECT && fill_r == HDR_BYTES))
    else $error("header match did not start collection");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COLLECT |-> (fill_r >= HDR_BYTES && fill_r <= LAST_IDX))
    else $error("fill count out of range while collecting");

  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_last && !out_stall && !ctl.out_load) |=> !busy_r)
    else $error("result run continued past the final word");

endmodule
`default_nettype wire

### hw/rtl/header_tail_frame_sync.sv
// Top level of the header/tail frame synchronizer: config registers and cell chains.
//
// Usage: one received byte enters per word on the in_ channel (in_valid,
// in_stall, in_rx_byte). The block hunts for the first header, requires the
// second header right after it and collects bytes until a full frame of
// FRAME_LENGTH bytes is held. If the final byte equals the tail register the
// frame is delivered on the out_ channel as FRAME_LENGTH words (byte, position,
// last flag); a bad tail drops the frame silently.
// Throughput: one input word per cycle while in_stall is low. The first result
// word is valid in the cycle after the final frame byte is accepted, and a frame
// drains at one word per cycle unless out_stall holds it, FRAME_LENGTH words in all.
// Frames are collected in one chain of byte cells and copied whole into a
// second chain that shifts out, so collection of the next frame overlaps
// delivery. in_stall rises only when a frame is complete while the previous
// one is still being delivered, which happens only if out_stall held it back.
// A stall on the output simply holds the current word.
// Reset (rst_n, synchronous, active low) clears the registers to zero and the
// block to the hunting state with no result pending. Registers must be written
// over the APB port only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module header_tail_frame_sync
  import htfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [BYTE_W-1:0] out_frame_byte,
  output logic      [POS_W-1:0]  out_byte_position,
  output logic                   out_frame_last
);

  logic [BYTE_W-1:0] first_hdr_r, second_hdr_r, tail_r;
  logic [1:0]        reg_idx;
  logic              wr_en;
  ctl_t              ctl;

  logic [BYTE_W-1:0] coll_q  [FRAME_LENGTH];
  logic [BYTE_W-1:0] coll_in [FRAME_LENGTH];
  logic [BYTE_W-1:0] out_q   [FRAME_LENGTH];

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r  <= '0;
      second_hdr_r <= '0;
      tail_r       <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FIRST_HDR:  first_hdr_r  <= pwdata[BYTE_W-1:0];
        REG_SECOND_HDR: second_hdr_r <= pwdata[BYTE_W-1:0];
        REG_TAIL:       tail_r       <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIRST_HDR:  prdata = DATA_W'(first_hdr_r);
      REG_SECOND_HDR: prdata = DATA_W'(second_hdr_r);
      REG_TAIL:       prdata = DATA_W'(tail_r);
      default:        prdata = '0;
    endcase
  end

  htfs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .rx_byte      (in_rx_byte),
    .first_hdr    (first_hdr_r),
    .second_hdr   (second_hdr_r),
    .tail         (tail_r),
    .out_stall    (out_stall),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_position (out_byte_position),
    .out_last     (out_frame_last),
    .ctl          (ctl)
  );

  // Both chains shift toward cell 0; new bytes enter at the far end, so after
  // a full frame cell 0 holds the first header.
  for (genvar i = 0; i < FRAME_LENGTH; i++) begin : g_cells
    logic              hdr_en;
    logic [BYTE_W-1:0] hdr_val;
    logic [BYTE_W-1:0] out_in;

    if (i == FRAME_LENGTH - 1) begin : g_end
      assign coll_in[i] = in_rx_byte;
      assign out_in     = '0;
    end else begin : g_mid
      assign coll_in[i] = coll_q[i+1];
      assign out_in     = out_q[i+1];
    end

    // The header cycle places both header bytes in the last two cells.
    if (i == FRAME_LENGTH - 2) begin : g_hdr1
      assign hdr_en  = ctl.hdr_load;
      assign hdr_val = first_hdr_r;
    end else if (i == FRAME_LENGTH - 1) begin : g_hdr2
      assign hdr_en  = ctl.hdr_load;
      assign hdr_val = second_hdr_r;
    end else begin : g_nohdr
      assign hdr_en  = 1'b0;
      assign hdr_val = '0;
    end

    htfs_cell u_coll (
      .clk      (clk),
      .shift_en (ctl.coll_shift),
      .shift_in (coll_in[i]),
      .load_en  (hdr_en),
      .load_in  (hdr_val),
      .q        (coll_q[i])
    );

    // On a good tail the result chain takes the frame including the byte
    // arriving in that same cycle.
    htfs_cell u_out (
      .clk      (clk),
      .shift_en (ctl.out_shift),
      .shift_in (out_in),
      .load_en  (ctl.out_load),
      .load_in  (coll_in[i]),
      .q        (out_q[i])
    );
  end

  assign out_frame_byte = out_q[0];

endmodule
`default_nettype wire

### tb/header_tail_frame_sync_test.sv
// Self-checking testbench for the header/tail frame synchronizer.
`timescale 1ns / 1ps
module header_tail_frame_sync_test;
  import htfs_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] fbyte;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_word_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // A byte row sends value (or a ramp starting at value) reps times; words is the
  // number of frame words the last byte of the row releases.
  // The register index only matters on configuration rows.
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [7:0]  value;
    logic [7:0]  reps;
    logic        ramp;
    logic [7:0]  words;
  } stim_row_t;

  localparam int DIR_ROWS = 25;
  localparam logic [7:0] FULL = 8'(FRAME_LENGTH);
  localparam logic [7:0] BODY = 8'(FRAME_LENGTH - 3);

  stim_row_t dir_rows [DIR_ROWS] = '{
    // Reset values: both headers and the tail are zero.
    '{ROW_BYTE, REG_FIRST_HDR,  8'h00, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h00, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h01, BODY, 1'b1, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h00, 8'd1, 1'b0, FULL},
    '{ROW_CFG,  REG_FIRST_HDR,  8'hA5, 8'd1, 1'b0, 8'd0},
    '{ROW_CFG,  REG_SECOND_HDR, 8'h5A, 8'd1, 1'b0, 8'd0},
    '{ROW_CFG,  REG_TAIL,       8'hFF, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h00, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hFF, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h5A, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hA5, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h11, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hA5, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hA5, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h5A, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h80, BODY, 1'b1, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hFF, 8'd1, 1'b0, FULL},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hA5, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h5A, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hA5, BODY, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h00, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hA5, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'h5A, 8'd1, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hFF, BODY, 1'b0, 8'd0},
    '{ROW_BYTE, REG_FIRST_HDR,  8'hFF, 8'd1, 1'b0, FULL}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_frame_byte;
  logic [POS_W-1:0]  out_byte_position;
  logic              out_frame_last;

  // Predictor state, mirroring the block's registers and frame buffer.
  logic [7:0]  hdr1_val = 8'h00;
  logic [7:0]  hdr2_val = 8'h00;
  logic [7:0]  tail_val = 8'h00;
  phase_t      sync_ph = PH_HUNT;
  int          fill = 0;
  logic [7:0]  frame_buf [FRAME_LENGTH];
  frame_word_t expected_words [$];

  int err_count = 0;
  int sent_count = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  header_tail_frame_sync dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_frame_byte(out_frame_byte), .out_byte_position(out_byte_position),
    .out_frame_last(out_frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advances the frame hunter by one byte and queues any frame it releases.
  function int sync_on_byte(input logic [7:0] b);
    int k;
    int n;
    n = 0;
    case (sync_ph)
      PH_WAIT2: begin
        if (b == hdr2_val) begin
          frame_buf[0] = hdr1_val;
          frame_buf[1] = hdr2_val;
          fill = 2;
          sync_ph = PH_COLLECT;
        end else if (b != hdr1_val) begin
          sync_ph = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        frame_buf[fill] = b;
        fill++;
        if (fill >= FRAME_LENGTH) begin
          if (b == tail_val) begin
            for (k = 0; k < FRAME_LENGTH; k++)
              expected_words.push_back('{frame_buf[k], POS_W'(k), k == FRAME_LENGTH - 1});
            n = FRAME_LENGTH;
          end
          fill = 0;
          sync_ph = PH_HUNT;
        end
      end
      default: sync_ph = (b == hdr1_val) ? PH_WAIT2 : PH_HUNT;
    endcase
    return n;
  endfunction

  function logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == hdr1_val || b == hdr2_val || b == tail_val);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, output int words);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    words = sync_on_byte(b);
    sent_count++;
  endtask

  // Drops the input and lets the block drain before registers are touched.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'({idx, 2'b00});
    pwdata = $urandom;
    pwdata[7:0] = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FIRST_HDR:  hdr1_val = val;
      REG_SECOND_HDR: hdr2_val = val;
      REG_TAIL:       tail_val = val;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Mostly whole frames with random bodies, plus broken header pairs and noise.
  task automatic send_random_sequence();
    int r;
    int n;
    calm = ($urandom_range(0, 7) == 0);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send_byte(hdr1_val, n);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_byte(hdr1_val, n);
      send_byte(hdr2_val, n);
      repeat (FRAME_LENGTH - 3) send_byte(8'($urandom), n);
      send_byte(($urandom_range(0, 3) != 0) ? tail_val : 8'($urandom), n);
    end else if (r < 85) begin
      send_byte(hdr1_val, n);
      send_byte(8'($urandom), n);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), n);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    err_count++;
    if (err_count <= 40)
      $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
  endtask

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    frame_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        err_count++;
        if (err_count <= 40)
          $display("%0t ns: unexpected word byte %h position %0d last %b", $time,
                   out_frame_byte, out_byte_position, out_frame_last);
      end else begin
        want = expected_words.pop_front();
        if (out_frame_byte !== want.fbyte)
          report_mismatch("frame_byte", want.fbyte, out_frame_byte);
        if (out_byte_position !== want.pos)
          report_mismatch("byte_position", 8'(want.pos), 8'(out_byte_position));
        if (out_frame_last !== want.last)
          report_mismatch("frame_last", 8'(want.last), 8'(out_frame_last));
      end
    end
  end

  initial begin
    int row;
    int r;
    int ph;
    int n;
    int start;
    logic [7:0] b;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (row = 0; row < DIR_ROWS; row++) begin
      if (dir_rows[row].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[row].reg_idx, dir_rows[row].value);
      end else begin
        for (r = 0; r < int'(dir_rows[row].reps); r++) begin
          b = dir_rows[row].ramp ? dir_rows[row].value + 8'(r) : dir_rows[row].value;
          send_byte(b, n);
        end
        if (n != int'(dir_rows[row].words)) begin
          err_count++;
          $display("%0t ns: row %0d expected %0d frame words, predicted %0d", $time,
                   row, dir_rows[row].words, n);
        end
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_FIRST_HDR, 8'h00);
          write_reg(REG_SECOND_HDR, 8'hFF);
          write_reg(REG_TAIL, 8'h00);
        end
        1: begin
          write_reg(REG_FIRST_HDR, 8'hFF);
          write_reg(REG_SECOND_HDR, 8'h00);
          write_reg(REG_TAIL, 8'hFF);
        end
        2: begin
          write_reg(REG_FIRST_HDR, 8'h3C);
          write_reg(REG_SECOND_HDR, 8'h3C);
          write_reg(REG_TAIL, 8'h81);
        end
        default: begin
          write_reg(REG_FIRST_HDR, 8'($urandom));
          write_reg(REG_SECOND_HDR, 8'($urandom));
          write_reg(REG_TAIL, 8'($urandom));
        end
      endcase
      start = sent_count;
      while (sent_count - start < 55) send_random_sequence();
      // Leave the block hunting so the next register writes land between frames.
      calm = 1'b0;
      while (sync_ph != PH_HUNT) send_byte(filler_byte(), n);
    end

    wait_idle();
    repeat (FRAME_LENGTH) @(posedge clk);
    if (err_count == 0)
      $display("** header_tail_frame_sync: PASSED **");
    else
      $display("** header_tail_frame_sync: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** header_tail_frame_sync: FAILED **");
    $finish;
  end

endmodule
